// ===== rtl/wla_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wla_pkg: shared constants and helpers for the windowed load average
// Window lengths, ring depth, derived widths, reciprocals and the leaving-slot function.
// ----------------------------------------------------------------------------
package wla_pkg;

   localparam int HISTORY_DEPTH = 1024;
   localparam int SHORT_WINDOW  = 60;
   localparam int MID_WINDOW    = 300;
   localparam int LONG_WINDOW   = 900;

   localparam int FULL_SCALE    = 25600;
   localparam int COUNT_W       = 32;
   localparam int LOAD_W        = 15;
   localparam int IDX_W         = $clog2(HISTORY_DEPTH);

   // Divider datapath: numerator is count times full scale, quotient fits LOAD_W.
   localparam int DIV_D_W       = COUNT_W;
   localparam int DIV_Q_W       = LOAD_W;
   localparam int DIV_N_W       = DIV_D_W + DIV_Q_W;
   localparam int DIV_CNT_W     = $clog2(DIV_Q_W);

   localparam int SHORT_SUM_W   = $clog2(SHORT_WINDOW * FULL_SCALE + 1);
   localparam int MID_SUM_W     = $clog2(MID_WINDOW * FULL_SCALE + 1);
   localparam int LONG_SUM_W    = $clog2(LONG_WINDOW * FULL_SCALE + 1);

   localparam int SHORT_BACK    = SHORT_WINDOW % HISTORY_DEPTH;
   localparam int MID_BACK      = MID_WINDOW % HISTORY_DEPTH;
   localparam int LONG_BACK     = LONG_WINDOW % HISTORY_DEPTH;

   // Window means by reciprocal multiplication: mean = (sum * RECIP) >> RECIP_SHIFT.
   // With windows up to 1023 the sum times the rounding error of RECIP stays
   // below 2^RECIP_SHIFT, so the truncated quotient is exact.
   localparam int     RECIP_SHIFT   = 36;
   localparam longint SHORT_RECIP   =
      ((longint'(1) << RECIP_SHIFT) + SHORT_WINDOW - 1) / SHORT_WINDOW;
   localparam longint MID_RECIP     =
      ((longint'(1) << RECIP_SHIFT) + MID_WINDOW - 1) / MID_WINDOW;
   localparam longint LONG_RECIP    =
      ((longint'(1) << RECIP_SHIFT) + LONG_WINDOW - 1) / LONG_WINDOW;
   localparam int     SHORT_PROD_W  = SHORT_SUM_W + $clog2(SHORT_RECIP + 1);
   localparam int     MID_PROD_W    = MID_SUM_W + $clog2(MID_RECIP + 1);
   localparam int     LONG_PROD_W   = LONG_SUM_W + $clog2(LONG_RECIP + 1);

   // Slot that holds the sample leaving a window, 'back' places behind idx.
   function automatic logic [IDX_W-1:0] leaving_slot(input logic [IDX_W-1:0] idx,
                                                     input int back);
      logic [IDX_W:0] wide;
      logic [IDX_W-1:0] slot;
      wide = {1'b0, idx};
      if (wide >= (IDX_W+1)'(back)) begin
         slot = IDX_W'(wide - (IDX_W+1)'(back));
      end else begin
         slot = IDX_W'(wide + (IDX_W+1)'(HISTORY_DEPTH - back));
      end
      return slot;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/wla_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wla_req_if: request channel of the windowed load average
// Valid/ready handshake carrying the two cumulative tick counters.
// ----------------------------------------------------------------------------
interface wla_req_if;
   logic                             valid;
   logic                             ready;
   logic [wla_pkg::COUNT_W-1:0]      busy_count;
   logic [wla_pkg::COUNT_W-1:0]      total_count;

   modport source (output valid, output busy_count, output total_count, input ready);
   modport sink   (input valid, input busy_count, input total_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/wla_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wla_rsp_if: response channel of the windowed load average
// Valid/ready handshake carrying the sample, three averages and the idle flag.
// ----------------------------------------------------------------------------
interface wla_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [wla_pkg::LOAD_W-1:0]       current_load;
   logic [wla_pkg::LOAD_W-1:0]       avg_short;
   logic [wla_pkg::LOAD_W-1:0]       avg_mid;
   logic [wla_pkg::LOAD_W-1:0]       avg_long;
   logic                             idle_interval_flag;

   modport source (output valid, output current_load, output avg_short, output avg_mid,
                   output avg_long, output idle_interval_flag, input ready);
   modport sink   (input valid, input current_load, input avg_short, input avg_mid,
                   input avg_long, input idle_interval_flag, output ready);
endinterface
`default_nettype wire

// ===== rtl/windowed_load_average_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_load_average_top: multi-window moving average of processor load
// Turns cumulative busy/total tick counters into a load sample (percent x 256)
// and keeps exact sums over the short, middle and long windows in a ring.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake     carries
//   req_chan  in         valid/ready   busy_count, total_count
//   rsp_chan  out        valid/ready   current_load, avg_short, avg_mid,
//                                      avg_long, idle_interval_flag
//
// A request runs through the ring read/capture states S_RD1 to S_RD3, a wait
// in S_DIV on the bit-serial sample divider (which forms the 15 quotient bits
// and raises done), the write-back in S_SUM and the response load in S_OUT,
// then returns to S_IDLE to take the next request. An idle interval or a
// saturated sample skips the divider. Only the sample divider is iterative;
// the window means come from reciprocal multiplies.
// Reset is synchronous; the ring needs no clearing pass, since a fill mark
// (write index plus wrap flag) makes unwritten slots read as zero.
// A new request is taken while the previous response still waits; the block
// only stalls in its last step if that response has not been taken yet.
// ----------------------------------------------------------------------------
module windowed_load_average_top (
   input  wire logic   clock,
   input  wire logic   reset,
   wla_req_if.sink     req_chan,
   wla_rsp_if.source   rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_RD3,
      S_DIV,
      S_SUM,
      S_OUT
   } state_type;

   state_type                          state_ff;

   // counters and deltas
   logic [wla_pkg::COUNT_W-1:0]        prev_busy_ff;
   logic [wla_pkg::COUNT_W-1:0]        prev_total_ff;
   logic [wla_pkg::COUNT_W-1:0]        d_busy_ff;
   logic [wla_pkg::COUNT_W-1:0]        d_total_ff;
   logic [wla_pkg::DIV_N_W-1:0]        product_ff;

   // ring bookkeeping
   logic [wla_pkg::IDX_W-1:0]          wr_idx_ff;
   logic [wla_pkg::IDX_W-1:0]          wr_idx_in;
   logic                               wrapped_ff;
   logic                               rd_ok_ff;
   logic                               rd_ok_in;
   logic [wla_pkg::IDX_W-1:0]          rd_addr;
   logic [wla_pkg::LOAD_W-1:0]         rd_data;
   logic [wla_pkg::LOAD_W-1:0]         rd_masked;
   logic [wla_pkg::LOAD_W-1:0]         old_short_ff;
   logic [wla_pkg::LOAD_W-1:0]         old_mid_ff;
   logic [wla_pkg::LOAD_W-1:0]         old_long_ff;
   logic                               ram_we;

   // sample and sums
   logic [wla_pkg::LOAD_W-1:0]         sample_ff;
   logic                               idle_ff;
   logic [wla_pkg::SHORT_SUM_W-1:0]    short_sum_ff;
   logic [wla_pkg::SHORT_SUM_W-1:0]    short_sum_in;
   logic [wla_pkg::MID_SUM_W-1:0]      mid_sum_ff;
   logic [wla_pkg::MID_SUM_W-1:0]      mid_sum_in;
   logic [wla_pkg::LONG_SUM_W-1:0]     long_sum_ff;
   logic [wla_pkg::LONG_SUM_W-1:0]     long_sum_in;

   // sample divider and window means
   logic                               samp_start;
   logic                               samp_done;
   logic [wla_pkg::DIV_Q_W-1:0]        samp_quo;
   logic [wla_pkg::SHORT_PROD_W-1:0]   short_prod;
   logic [wla_pkg::MID_PROD_W-1:0]     mid_prod;
   logic [wla_pkg::LONG_PROD_W-1:0]    long_prod;
   logic [wla_pkg::LOAD_W-1:0]         short_quo;
   logic [wla_pkg::LOAD_W-1:0]         mid_quo;
   logic [wla_pkg::LOAD_W-1:0]         long_quo;

   // response register
   logic                               rsp_valid_ff;
   logic [wla_pkg::LOAD_W-1:0]         rsp_load_ff;
   logic [wla_pkg::LOAD_W-1:0]         rsp_short_ff;
   logic [wla_pkg::LOAD_W-1:0]         rsp_mid_ff;
   logic [wla_pkg::LOAD_W-1:0]         rsp_long_ff;
   logic                               rsp_idle_ff;

   logic                               req_take;
   logic                               rsp_take;
   logic                               rsp_free;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // -------------------------------------------------------------------------
   // Ring read sequencing: one leaving slot per cycle, short, mid, then long.
   // A slot is only trusted once written since reset; otherwise it reads zero.
   // -------------------------------------------------------------------------
   always_comb begin
      case (state_ff)
         S_RD1:   rd_addr = wla_pkg::leaving_slot(wr_idx_ff, wla_pkg::MID_BACK);
         S_RD2:   rd_addr = wla_pkg::leaving_slot(wr_idx_ff, wla_pkg::LONG_BACK);
         default: rd_addr = wla_pkg::leaving_slot(wr_idx_ff, wla_pkg::SHORT_BACK);
      endcase
      rd_ok_in  = wrapped_ff || (rd_addr < wr_idx_ff);
      rd_masked = rd_ok_ff ? rd_data : '0;
   end

   // advance the write index, wrapping at the ring depth
   assign wr_idx_in = (wr_idx_ff == wla_pkg::IDX_W'(wla_pkg::HISTORY_DEPTH - 1))
                      ? '0 : wr_idx_ff + 1'b1;

   // slide each window: add the new sample, drop the leaving one
   assign short_sum_in = wla_pkg::SHORT_SUM_W'(
      ({1'b0, short_sum_ff} + (wla_pkg::SHORT_SUM_W+1)'(sample_ff))
      - (wla_pkg::SHORT_SUM_W+1)'(old_short_ff));
   assign mid_sum_in = wla_pkg::MID_SUM_W'(
      ({1'b0, mid_sum_ff} + (wla_pkg::MID_SUM_W+1)'(sample_ff))
      - (wla_pkg::MID_SUM_W+1)'(old_mid_ff));
   assign long_sum_in = wla_pkg::LONG_SUM_W'(
      ({1'b0, long_sum_ff} + (wla_pkg::LONG_SUM_W+1)'(sample_ff))
      - (wla_pkg::LONG_SUM_W+1)'(old_long_ff));

   // window means: multiply by the scaled reciprocal, keep the integer part
   assign short_prod = wla_pkg::SHORT_PROD_W'(short_sum_ff)
                       * wla_pkg::SHORT_PROD_W'(wla_pkg::SHORT_RECIP);
   assign mid_prod   = wla_pkg::MID_PROD_W'(mid_sum_ff)
                       * wla_pkg::MID_PROD_W'(wla_pkg::MID_RECIP);
   assign long_prod  = wla_pkg::LONG_PROD_W'(long_sum_ff)
                       * wla_pkg::LONG_PROD_W'(wla_pkg::LONG_RECIP);
   assign short_quo  = short_prod[wla_pkg::RECIP_SHIFT +: wla_pkg::LOAD_W];
   assign mid_quo    = mid_prod[wla_pkg::RECIP_SHIFT +: wla_pkg::LOAD_W];
   assign long_quo   = long_prod[wla_pkg::RECIP_SHIFT +: wla_pkg::LOAD_W];

   // start the sample divider only for a genuine fraction below full scale
   assign samp_start = (state_ff == S_RD3) && (d_total_ff != '0) && (d_busy_ff < d_total_ff);
   assign ram_we     = (state_ff == S_SUM);

   // -------------------------------------------------------------------------
   // Sequencer: state, control and registered outputs.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_busy_ff  <= '0;
         prev_total_ff <= '0;
         wr_idx_ff     <= '0;
         wrapped_ff    <= 1'b0;
         short_sum_ff  <= '0;
         mid_sum_ff    <= '0;
         long_sum_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // raise valid on a fresh response, drop it once the last one is taken
         if ((state_ff == S_OUT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  // form the deltas modulo 2^32 and hold the new counters
                  d_busy_ff     <= req_chan.busy_count - prev_busy_ff;
                  d_total_ff    <= req_chan.total_count - prev_total_ff;
                  prev_busy_ff  <= req_chan.busy_count;
                  prev_total_ff <= req_chan.total_count;
                  rd_ok_ff      <= rd_ok_in;
                  state_ff      <= S_RD1;
               end
            end
            S_RD1: begin
               product_ff   <= wla_pkg::DIV_N_W'(d_busy_ff) *
                               wla_pkg::DIV_N_W'(wla_pkg::FULL_SCALE);
               old_short_ff <= rd_masked;
               rd_ok_ff     <= rd_ok_in;
               state_ff     <= S_RD2;
            end
            S_RD2: begin
               old_mid_ff <= rd_masked;
               rd_ok_ff   <= rd_ok_in;
               state_ff   <= S_RD3;
            end
            S_RD3: begin
               old_long_ff <= rd_masked;
               if (d_total_ff == '0) begin
                  // no ticks elapsed: force the sample to zero and flag it
                  sample_ff <= '0;
                  idle_ff   <= 1'b1;
                  state_ff  <= S_SUM;
               end else if (d_busy_ff >= d_total_ff) begin
                  // saturate at full scale
                  sample_ff <= wla_pkg::LOAD_W'(wla_pkg::FULL_SCALE);
                  idle_ff   <= 1'b0;
                  state_ff  <= S_SUM;
               end else begin
                  idle_ff  <= 1'b0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (samp_done) begin
                  sample_ff <= samp_quo;
                  state_ff  <= S_SUM;
               end
            end
            S_SUM: begin
               short_sum_ff <= short_sum_in;
               mid_sum_ff   <= mid_sum_in;
               long_sum_ff  <= long_sum_in;
               wr_idx_ff    <= wr_idx_in;
               if (wr_idx_ff == wla_pkg::IDX_W'(wla_pkg::HISTORY_DEPTH - 1)) begin
                  wrapped_ff <= 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // hold until the previous response has gone
               if (rsp_free) begin
                  rsp_load_ff  <= sample_ff;
                  rsp_short_ff <= short_quo;
                  rsp_mid_ff   <= mid_quo;
                  rsp_long_ff  <= long_quo;
                  rsp_idle_ff  <= idle_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Sample history ring
   // -------------------------------------------------------------------------
   wla_ram #(
      .WIDTH (wla_pkg::LOAD_W),
      .DEPTH (wla_pkg::HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (sample_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // -------------------------------------------------------------------------
   // Sample ratio divider
   // -------------------------------------------------------------------------
   wla_div u_samp_div (
      .clock    (clock),
      .reset    (reset),
      .start    (samp_start),
      .dividend (product_ff),
      .divisor  (d_total_ff),
      .done     (samp_done),
      .quotient (samp_quo)
   );

   // -------------------------------------------------------------------------
   // Channel wiring
   // -------------------------------------------------------------------------
   assign req_chan.ready              = (state_ff == S_IDLE);
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.current_load       = rsp_load_ff;
   assign rsp_chan.avg_short          = rsp_short_ff;
   assign rsp_chan.avg_mid            = rsp_mid_ff;
   assign rsp_chan.avg_long           = rsp_long_ff;
   assign rsp_chan.idle_interval_flag = rsp_idle_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   // a waiting response holds its valid, its load and its three averages until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff && $stable(rsp_load_ff) &&
      $stable(rsp_short_ff) && $stable(rsp_mid_ff) && $stable(rsp_long_ff))
      else $error("response changed while waiting");

   // the sample divider only reports while the sequencer waits for it
   a_samp_done_state: assert property (@(posedge clock) disable iff (reset)
      samp_done |-> (state_ff == S_DIV))
      else $error("sample divider finished outside its wait state");

   // a window sum can never exceed its length times full scale
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(short_sum_ff) <= 32'(wla_pkg::SHORT_WINDOW * wla_pkg::FULL_SCALE)) &&
      (32'(mid_sum_ff)   <= 32'(wla_pkg::MID_WINDOW * wla_pkg::FULL_SCALE)) &&
      (32'(long_sum_ff)  <= 32'(wla_pkg::LONG_WINDOW * wla_pkg::FULL_SCALE)))
      else $error("window sum beyond its bound");

   // the write index advances by one per completed request and stays in range
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=> (wr_idx_ff == $past(wr_idx_in)) &&
      (32'(wr_idx_ff) < 32'(wla_pkg::HISTORY_DEPTH)))
      else $error("ring write index slipped");

endmodule
`default_nettype wire

// ===== rtl/wla_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wla_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wla_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/wla_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wla_div: iterative restoring divider
// One quotient bit per cycle; the caller guarantees the quotient fits DIV_Q_W.
// ----------------------------------------------------------------------------
module wla_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [wla_pkg::DIV_N_W-1:0]  dividend,
   input  wire logic [wla_pkg::DIV_D_W-1:0]  divisor,
   output      logic                         done,
   output      logic [wla_pkg::DIV_Q_W-1:0]  quotient
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [wla_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [wla_pkg::DIV_D_W-1:0]    rem_ff;
   logic [wla_pkg::DIV_Q_W-1:0]    quo_ff;
   logic [wla_pkg::DIV_D_W-1:0]    div_ff;

   logic [wla_pkg::DIV_D_W:0]      trial;
   logic                           fits;
   logic [wla_pkg::DIV_D_W-1:0]    rem_in;

   // shift in the next numerator bit, subtract where the divisor fits
   always_comb begin
      trial  = {rem_ff, quo_ff[wla_pkg::DIV_Q_W-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? wla_pkg::DIV_D_W'(trial - {1'b0, div_ff})
                    : wla_pkg::DIV_D_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == wla_pkg::DIV_CNT_W'(wla_pkg::DIV_Q_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[wla_pkg::DIV_N_W-1:wla_pkg::DIV_Q_W];
         quo_ff <= dividend[wla_pkg::DIV_Q_W-1:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[wla_pkg::DIV_Q_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
